>>> hdl/lpd_pkg.sv
package lpd_pkg;

    // Item kinds on the input channel.
    localparam logic [1:0] FN_BYTE  = 2'd0;
    localparam logic [1:0] FN_TICK  = 2'd1;
    localparam logic [1:0] FN_OPEN  = 2'd2;
    // The fourth code carries no meaning and is ignored.
    localparam logic [1:0] FN_SPARE = 2'd3;

    // Result kinds on the output channel.
    localparam logic [2:0] RK_BYTE   = 3'd0;
    localparam logic [2:0] RK_EMPTY  = 3'd1;
    localparam logic [2:0] RK_BADLEN = 3'd2;
    localparam logic [2:0] RK_HDR_TO = 3'd3;
    localparam logic [2:0] RK_PAY_TO = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MAX_LENGTH      = 2'd0;
    localparam logic [1:0] CFG_PAYLOAD_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_HEADER_TIMEOUT  = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [31:0] MAX_LENGTH_RST      = 32'd1048576;
    localparam logic [15:0] PAYLOAD_TIMEOUT_RST = 16'd5;
    localparam logic [15:0] HEADER_TIMEOUT_RST  = 16'd15;

    // Index of the final header byte (four bytes, big-endian).
    localparam logic [1:0] HDR_LAST_IDX = 2'd3;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_CLOSED  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [31:0] max_length;
        logic [15:0] payload_timeout;
        logic [15:0] header_timeout;
    } t_cfg;

    typedef struct packed {
        logic        vld;
        logic [2:0]  kind;
        logic [7:0]  data;
        logic        last;
        logic [31:0] length;
    } t_result;

endpackage

>>> hdl/length_prefix_deframer_with_timeouts.sv
// Channel  | Direction | Handshake                  | Payload
// input    | in        | i_in_valid / o_in_ready    | i_func, i_data_byte
// output   | out       | o_out_valid / i_out_ready  | o_result_kind, o_out_byte,
//          |           |                            | o_out_last, o_frame_length
// config   | in        | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_data
//
// One item is taken in every cycle while o_in_ready is high; an accepted item
// passes through the input register, then the step logic into the result register.
// The rate is set by the state update in the step engine, made once per item.
// Reset is synchronous and active low; it restores the register defaults and
// an empty header phase. A stalled result register holds the input register,
// and o_in_ready falls only when both stages are full.

module length_prefix_deframer_with_timeouts
    import lpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    // Input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_data_byte,
    // Output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_result_kind,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last,
    output logic [31:0] o_frame_length
);

    t_cfg    cfg;
    t_result res;

    logic        r_in_vld;
    logic [1:0]  r_in_func;
    logic [7:0]  r_in_byte;
    logic        r_out_vld;
    t_result     r_out;
    logic        advance;
    logic        step;

    lpd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // The result register can take a new value when it is empty or being
    // drained this cycle. An item in the input register is processed only
    // then, so that every state update has a slot for its result.
    assign advance    = !r_out_vld || i_out_ready;
    assign step       = r_in_vld && advance;
    assign o_in_ready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in_func <= i_func;
            r_in_byte <= i_data_byte;
        end
    end

    lpd_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_func      (r_in_func),
        .i_data_byte (r_in_byte),
        .i_cfg       (cfg),
        .o_res       (res)
    );

    // Items that cause no result simply leave the result register empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= step && res.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_result_kind  = r_out.kind;
    assign o_out_byte     = r_out.data;
    assign o_out_last     = r_out.last;
    assign o_frame_length = r_out.length;

`ifndef SYNTHESIS
    // Only payload byte results carry a byte or a last marker.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_kind != RK_BYTE) |-> (o_out_byte == 8'd0) && !o_out_last)
        else $error("non-byte result carries byte data");

    // Header timeouts and empty messages report a zero length.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_result_kind == RK_HDR_TO) || (o_result_kind == RK_EMPTY))
        |-> (o_frame_length == 32'd0))
        else $error("length reported with header timeout or empty message");

    // A bad length result always exceeds the configured maximum.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_kind == RK_BADLEN) |-> (o_frame_length > cfg.max_length))
        else $error("bad length result within the maximum");

    // A held input item is not lost while the result register stalls.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !advance |=> r_in_vld && $stable(r_in_func) && $stable(r_in_byte))
        else $error("input register changed while stalled");
`endif

endmodule

>>> hdl/lpd_cfg.sv
module lpd_cfg
    import lpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_length      <= MAX_LENGTH_RST;
            r_cfg.payload_timeout <= PAYLOAD_TIMEOUT_RST;
            r_cfg.header_timeout  <= HEADER_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_LENGTH:      r_cfg.max_length      <= i_cfg_data;
                CFG_PAYLOAD_TIMEOUT: r_cfg.payload_timeout <= i_cfg_data[15:0];
                CFG_HEADER_TIMEOUT:  r_cfg.header_timeout  <= i_cfg_data[15:0];
                default: begin
                    // Writes to an unused index are dropped.
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hdl/lpd_engine.sv
module lpd_engine
    import lpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_data_byte,
    input  t_cfg        i_cfg,
    output t_result     o_res
);

    t_phase      r_phase,     n_phase;
    logic [1:0]  r_hdr_cnt,   n_hdr_cnt;
    logic [31:0] r_len,       n_len;
    logic [31:0] r_remain,    n_remain;
    logic [15:0] r_wait,      n_wait;

    logic [15:0] wait_inc;
    logic [31:0] hdr_len;
    logic        pay_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_hdr_cnt <= '0;
            r_len     <= '0;
            r_remain  <= '0;
            r_wait    <= '0;
        end else begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_len     <= n_len;
            r_remain  <= n_remain;
            r_wait    <= n_wait;
        end
    end

    // The tick counter saturates rather than wrapping.
    assign wait_inc = (&r_wait) ? r_wait : r_wait + 16'd1;
    assign hdr_len  = {r_len[23:0], i_data_byte};
    assign pay_last = (r_remain <= 32'd1);

    always_comb begin
        n_phase   = r_phase;
        n_hdr_cnt = r_hdr_cnt;
        n_len     = r_len;
        n_remain  = r_remain;
        n_wait    = r_wait;
        o_res     = '0;

        if (i_step) begin
            unique case (i_func)
                FN_OPEN: begin
                    n_phase   = PH_HEADER;
                    n_hdr_cnt = '0;
                    n_len     = '0;
                    n_remain  = '0;
                    n_wait    = '0;
                end
                FN_TICK: begin
                    if (r_phase == PH_PAYLOAD) begin
                        n_wait = wait_inc;
                        if (wait_inc >= i_cfg.payload_timeout) begin
                            o_res.vld    = 1'b1;
                            o_res.kind   = RK_PAY_TO;
                            o_res.length = r_len;
                            n_phase      = PH_CLOSED;
                        end
                    end else if (r_phase == PH_HEADER && r_hdr_cnt != 2'd0) begin
                        n_wait = wait_inc;
                        if (wait_inc >= i_cfg.header_timeout) begin
                            o_res.vld  = 1'b1;
                            o_res.kind = RK_HDR_TO;
                            n_phase    = PH_CLOSED;
                        end
                    end
                end
                FN_BYTE: begin
                    if (r_phase == PH_HEADER) begin
                        n_len = hdr_len;
                        if (r_hdr_cnt != HDR_LAST_IDX) begin
                            n_hdr_cnt = r_hdr_cnt + 2'd1;
                            if (r_hdr_cnt == 2'd0) begin
                                n_wait = '0;
                            end
                        end else begin
                            n_hdr_cnt = '0;
                            n_wait    = '0;
                            if (hdr_len > i_cfg.max_length) begin
                                o_res.vld    = 1'b1;
                                o_res.kind   = RK_BADLEN;
                                o_res.length = hdr_len;
                                n_phase      = PH_CLOSED;
                            end else if (hdr_len == 32'd0) begin
                                o_res.vld  = 1'b1;
                                o_res.kind = RK_EMPTY;
                            end else begin
                                n_remain = hdr_len;
                                n_phase  = PH_PAYLOAD;
                            end
                        end
                    end else if (r_phase == PH_PAYLOAD) begin
                        o_res.vld    = 1'b1;
                        o_res.kind   = RK_BYTE;
                        o_res.data   = i_data_byte;
                        o_res.last   = pay_last;
                        o_res.length = r_len;
                        if (pay_last) begin
                            n_phase   = PH_HEADER;
                            n_hdr_cnt = '0;
                            n_len     = '0;
                            n_remain  = '0;
                            n_wait    = '0;
                        end else begin
                            n_remain = r_remain - 32'd1;
                        end
                    end
                end
                default: begin
                    // The spare item code is ignored.
                end
            endcase
        end
    end

endmodule
